FILE: hdl/ute_pkg.sv
// ute_pkg: shared types, codes and helpers for the utf-8 terminal-safe escaper
// used by ute_scan and utf8_terminal_safe_escaper; no dependencies
`default_nettype none

package ute_pkg;

  localparam int unsigned CNT_BITS_DEF  = 32;
  localparam logic [31:0] LIMIT_RST     = 32'hFFFF_FFFF;
  localparam logic [7:0]  CHAR_BSLASH   = 8'h5C;
  localparam logic [7:0]  CHAR_X        = 8'h78;
  localparam logic [2:0]  ESC_LEN       = 3'd4;

  typedef logic [3:0][7:0] ute_buf_t;

  // scan verdict for the sequence at the head of the buffer
  typedef struct packed {
    logic       empty;
    logic       hold;
    logic       bad;
    logic       safe;
    logic [2:0] len;
  } ute_scan_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_EMIT  = 5'b01000,
    ST_FLUSH = 5'b10000
  } ute_state_t;

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] r;
    if (d < 4'd10) begin
      r = 8'h30 + {4'h0, d};
    end else begin
      r = 8'h37 + {4'h0, d};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/ute_scan.sv
// ute_scan: classifies the buffered sequence (length, validity, terminal safety)
// depends on ute_pkg
`default_nettype none

module ute_scan import ute_pkg::*; (
  input  ute_buf_t   buf_i,
  input  logic [2:0] n_i,
  input  logic       last_i,
  output ute_scan_t  scan_o
);

  function automatic logic byte_ok(input logic [7:0] first, input logic pos1,
                                   input logic [7:0] b);
    logic ok;
    ok = (b >= 8'h80) && (b <= 8'hBF);
    if (pos1) begin
      case (first)
        8'hE0:   ok = (b >= 8'hA0) && (b <= 8'hBF);
        8'hED:   ok = (b >= 8'h80) && (b <= 8'h9F);
        8'hF0:   ok = (b >= 8'h90) && (b <= 8'hBF);
        8'hF4:   ok = (b >= 8'h80) && (b <= 8'h8F);
        default: ok = ok;
      endcase
    end
    return ok;
  endfunction

  logic [7:0]  first;
  logic [2:0]  len;
  logic [2:0]  avail;
  logic        bad_bytes;
  logic        short;
  logic [20:0] cp;
  logic        safe;

  assign first = buf_i[0];

  always_comb begin
    if (first <= 8'h7F) begin
      len = 3'd1;
    end else if (first >= 8'hC2 && first <= 8'hDF) begin
      len = 3'd2;
    end else if (first >= 8'hE0 && first <= 8'hEF) begin
      len = 3'd3;
    end else if (first >= 8'hF0 && first <= 8'hF4) begin
      len = 3'd4;
    end else begin
      len = 3'd0;
    end
  end

  assign avail = (n_i < len) ? n_i : len;
  assign short = (n_i < len);

  always_comb begin
    bad_bytes = 1'b0;
    for (int i = 1; i < 4; i++) begin
      if (3'(i) < avail && !byte_ok(first, (i == 1), buf_i[i])) begin
        bad_bytes = 1'b1;
      end
    end
  end

  always_comb begin
    case (len)
      3'd1:    cp = {13'h0, first};
      3'd2:    cp = {10'h0, first[4:0], buf_i[1][5:0]};
      3'd3:    cp = {5'h0, first[3:0], buf_i[1][5:0], buf_i[2][5:0]};
      default: cp = {first[2:0], buf_i[1][5:0], buf_i[2][5:0], buf_i[3][5:0]};
    endcase
  end

  always_comb begin
    safe = 1'b1;
    if (cp < 21'h20) safe = 1'b0;
    if (cp >= 21'h7F && cp <= 21'h9F) safe = 1'b0;
    if (cp == 21'h5C || cp == 21'h2028 || cp == 21'h2029 || cp == 21'hFEFF) safe = 1'b0;
    if (cp == 21'h061C || cp == 21'h200E || cp == 21'h200F) safe = 1'b0;
    if (cp >= 21'h202A && cp <= 21'h202E) safe = 1'b0;
    if (cp >= 21'h2066 && cp <= 21'h2069) safe = 1'b0;
  end

  always_comb begin
    scan_o.empty = (n_i == 3'd0);
    scan_o.len   = len;
    scan_o.safe  = safe;
    scan_o.hold  = (len != 3'd0) && !bad_bytes && short && !last_i;
    scan_o.bad   = (len == 3'd0) || bad_bytes || (short && last_i);
  end

endmodule

`default_nettype wire

FILE: hdl/utf8_terminal_safe_escaper.sv
// utf8_terminal_safe_escaper: strict utf-8 check with \xHH escaping and output limit
// depends on ute_pkg and ute_scan
//
//  port group | dir | handshake           | payload
//  in_        | in  | in_valid / in_stall   | in_byte[7:0], in_last_byte
//  out_       | out | out_valid / out_stall | out_char[7:0], out_last_of_run,
//             |     |                       | out_limit_exceeded
//  cfg_       | in  | cfg_we                | cfg_wdata[31:0]
//
// one word: an accept step, a scan per sequence plus a closing scan, a check per
// chunk, an emit step per output char and a flush; a new byte is accepted only
// back in ST_IDLE, after the flush
// the single count adder/comparator checks the chunks one at a time in ST_CHECK
// synchronous active-low reset clears control, count and failure flag and sets the limit to all ones
// one char is held back to mark the last of a word; out_stall only freezes emission
`default_nettype none

module utf8_terminal_safe_escaper import ute_pkg::*; #(
  parameter int unsigned COUNT_BITS = CNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_char,
  output logic             out_last_of_run,
  output logic             out_limit_exceeded,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);

  localparam int unsigned CMPW = (COUNT_BITS + 1 > 32) ? COUNT_BITS + 1 : 32;

  ute_state_t            state_r, state_nxt;
  ute_buf_t              buf_r, buf_nxt, buf_shift;
  logic [2:0]            n_r, n_nxt;
  logic                  last_r, last_nxt;
  logic                  failed_r, failed_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [31:0]           limit_r;
  logic                  raw_r, raw_nxt;
  logic [2:0]            drop_r, drop_nxt;
  logic [1:0]            ci_r, ci_nxt;
  logic [1:0]            ei_r, ei_nxt;
  logic                  hold_v_r, hold_v_nxt;
  logic [7:0]            hold_c_r, hold_c_nxt;
  logic                  hold_e_r, hold_e_nxt;
  logic                  out_v_r, out_v_nxt;
  logic [7:0]            out_c_r, out_c_nxt;
  logic                  out_l_r, out_l_nxt;
  logic                  out_e_r, out_e_nxt;

  ute_scan_t             scan;
  logic                  out_free;
  logic                  slot_ok;
  logic [2:0]            clen;
  logic [COUNT_BITS:0]   sum;
  logic                  refuse;
  logic [7:0]            esc_byte;
  logic [7:0]            emit_c;
  logic                  chunk_done;

  ute_scan u_scan (
    .buf_i  (buf_r),
    .n_i    (n_r),
    .last_i (last_r),
    .scan_o (scan)
  );

  assign out_free = !out_v_r || !out_stall;
  assign slot_ok  = !hold_v_r || out_free;
  assign clen     = raw_r ? drop_r : ESC_LEN;
  assign sum      = {1'b0, count_r} + (COUNT_BITS+1)'(clen);
  assign refuse   = sum[COUNT_BITS] ||
                    (CMPW'(sum[COUNT_BITS-1:0]) > CMPW'(limit_r));
  assign esc_byte = buf_r[ei_r];

  always_comb begin
    if (raw_r) begin
      emit_c = buf_r[ci_r];
    end else begin
      case (ci_r)
        2'd0:    emit_c = CHAR_BSLASH;
        2'd1:    emit_c = CHAR_X;
        2'd2:    emit_c = hex_char(esc_byte[7:4]);
        default: emit_c = hex_char(esc_byte[3:0]);
      endcase
    end
  end

  assign chunk_done = raw_r ? ({1'b0, ci_r} + 3'd1 == drop_r) : (ci_r == 2'd3);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      logic [2:0] j;
      j = 3'(i) + drop_r;
      buf_shift[i] = (j < 3'd4) ? buf_r[j[1:0]] : 8'h00;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    buf_nxt    = buf_r;
    n_nxt      = n_r;
    last_nxt   = last_r;
    failed_nxt = failed_r;
    count_nxt  = count_r;
    raw_nxt    = raw_r;
    drop_nxt   = drop_r;
    ci_nxt     = ci_r;
    ei_nxt     = ei_r;
    hold_v_nxt = hold_v_r;
    hold_c_nxt = hold_c_r;
    hold_e_nxt = hold_e_r;
    out_v_nxt  = out_v_r && out_stall;
    out_c_nxt  = out_c_r;
    out_l_nxt  = out_l_r;
    out_e_nxt  = out_e_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && !failed_r) begin
          buf_nxt[n_r[1:0]] = in_byte;
          n_nxt             = n_r + 3'd1;
          last_nxt          = in_last_byte;
          state_nxt         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        ci_nxt = 2'd0;
        ei_nxt = 2'd0;
        if (scan.empty || scan.hold) begin
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_CHECK;
          if (scan.bad) begin
            raw_nxt  = 1'b0;
            drop_nxt = 3'd1;
          end else begin
            raw_nxt  = scan.safe;
            drop_nxt = scan.len;
          end
        end
      end
      ST_CHECK: begin
        if (refuse) begin
          if (slot_ok) begin
            if (hold_v_r) begin
              out_v_nxt = 1'b1;
              out_c_nxt = hold_c_r;
              out_l_nxt = 1'b0;
              out_e_nxt = hold_e_r;
            end
            hold_v_nxt = 1'b1;
            hold_c_nxt = 8'h00;
            hold_e_nxt = 1'b1;
            failed_nxt = 1'b1;
            n_nxt      = 3'd0;
            state_nxt  = ST_FLUSH;
          end
        end else begin
          count_nxt = sum[COUNT_BITS-1:0];
          ci_nxt    = 2'd0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_ok) begin
          if (hold_v_r) begin
            out_v_nxt = 1'b1;
            out_c_nxt = hold_c_r;
            out_l_nxt = 1'b0;
            out_e_nxt = hold_e_r;
          end
          hold_v_nxt = 1'b1;
          hold_c_nxt = emit_c;
          hold_e_nxt = 1'b0;
          ci_nxt     = ci_r + 2'd1;
          if (chunk_done) begin
            if (!raw_r && ({1'b0, ei_r} + 3'd1 != drop_r)) begin
              ei_nxt    = ei_r + 2'd1;
              state_nxt = ST_CHECK;
            end else begin
              buf_nxt   = buf_shift;
              n_nxt     = n_r - drop_r;
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_FLUSH: begin
        if (!hold_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_v_nxt  = 1'b1;
          out_c_nxt  = hold_c_r;
          out_l_nxt  = 1'b1;
          out_e_nxt  = hold_e_r;
          hold_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      n_r      <= 3'd0;
      failed_r <= 1'b0;
      count_r  <= '0;
      limit_r  <= LIMIT_RST;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      n_r      <= n_nxt;
      failed_r <= failed_nxt;
      count_r  <= count_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    buf_r    <= buf_nxt;
    last_r   <= last_nxt;
    raw_r    <= raw_nxt;
    drop_r   <= drop_nxt;
    ci_r     <= ci_nxt;
    ei_r     <= ei_nxt;
    hold_c_r <= hold_c_nxt;
    hold_e_r <= hold_e_nxt;
    out_c_r  <= out_c_nxt;
    out_l_r  <= out_l_nxt;
    out_e_r  <= out_e_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_v_r;
  assign out_char           = out_c_r;
  assign out_last_of_run    = out_l_r;
  assign out_limit_exceeded = out_e_r;

  // no held char survives the end of a word
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !hold_v_r)
    else $error("held char left over at idle");

  // at most three pending bytes between words
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> n_r <= 3'd3)
    else $error("pending byte count out of range");

  // the error word is zero and ends its run
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_e_r |-> out_l_r && (out_c_r == 8'h00))
    else $error("malformed limit error word");

  // the char count only grows
  a_count_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> count_r >= $past(count_r))
    else $error("output count went backwards");

endmodule

`default_nettype wire
